>>> design/bhpq_pkg.sv
// Shared constants for the binary heap priority queue.
// Field widths, command/status/config codes and parameter defaults.
// No dependencies.
package bhpq_pkg;

    // parameter defaults
    localparam int CAPACITY_DEF     = 1024;
    localparam int KEY_BITS_DEF     = 32;
    localparam int PAYLOAD_BITS_DEF = 32;

    // channel field widths
    localparam int CMD_W    = 1;
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int HELD_W   = 11;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_LARGEST_FIRST = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_KEYS   = 1'd1;

    // commands
    localparam logic [CMD_W-1:0] CMD_INSERT  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_EXTRACT = 1'b1;

    // result status
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

>>> design/bhpq_if.sv
// Valid/ready channel interfaces for the heap queue: request and response.
// Depends on bhpq_pkg for field widths.
interface bhpq_req_if;
    logic                          valid;
    logic                          ready;
    logic [bhpq_pkg::CMD_W-1:0]    cmd;
    logic [bhpq_pkg::KEY_W-1:0]    new_key;
    logic [bhpq_pkg::PAY_W-1:0]    new_payload;

    modport source (output valid, cmd, new_key, new_payload, input ready);
    modport sink   (input valid, cmd, new_key, new_payload, output ready);
endinterface

interface bhpq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bhpq_pkg::KEY_W-1:0]    top_key;
    logic [bhpq_pkg::PAY_W-1:0]    top_payload;
    logic [bhpq_pkg::STATUS_W-1:0] status;
    logic [bhpq_pkg::HELD_W-1:0]   entries_held;

    modport source (output valid, top_key, top_payload, status, entries_held, input ready);
    modport sink   (input valid, top_key, top_payload, status, entries_held, output ready);
endinterface

>>> design/bhpq_store.sv
// Heap entry store: one write port, two read ports, registered read data.
// No package dependencies.
module bhpq_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> design/binary_heap_priority_queue.sv
// Binary heap priority queue top level: sequencer, count and config registers.
// Depends on bhpq_pkg, bhpq_req_if/bhpq_rsp_if and bhpq_store.
//
//   channel  dir  transaction carries
//   -------  ---  -------------------------------------------------
//   req      in   cmd, new_key, new_payload
//   rsp      out  top_key, top_payload, status, entries_held
//   cfg_*    in   cfg_we, cfg_index, cfg_data (write only)
//
// One request at a time. Each heap level is one compare step: the store read
// issued in the previous cycle is compared against the moving entry and
// the winner is written back. From one accept to the next, an insert or an
// extract passes through the accept, one step per heap level that it walks
// (an extract spends one step reading root and last entry, then walks one
// level fewer), the write of the moving entry and the response. The response
// register lets a new request start while the last response waits; a
// stalled response holds the next one in its response state. Reset clears
// the entry count; the store is not cleared.
module binary_heap_priority_queue #(
    parameter int CAPACITY     = bhpq_pkg::CAPACITY_DEF,
    parameter int KEY_BITS     = bhpq_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = bhpq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bhpq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bhpq_pkg::CFG_DATA_W-1:0] cfg_data,
    bhpq_req_if.sink                        req,
    bhpq_rsp_if.source                      rsp
);

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int KID_W   = IDX_W + 2;
    localparam int ENT_W   = KEY_BITS + PAYLOAD_BITS;
    localparam int O_KEY_W = bhpq_pkg::KEY_W;
    localparam int O_PAY_W = bhpq_pkg::PAY_W;
    localparam int O_HLD_W = bhpq_pkg::HELD_W;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP_CMP  = 3'd1;
    localparam logic [2:0] S_DN_ROOT = 3'd2;
    localparam logic [2:0] S_DN_CMP  = 3'd3;
    localparam logic [2:0] S_WR_MOV  = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    // a ranks after b: b must be served first
    function automatic logic ranks_after(input logic [ENT_W-1:0] a,
                                         input logic [ENT_W-1:0] b,
                                         input logic lf,
                                         input logic sk);
        logic [KEY_BITS-1:0] ka;
        logic [KEY_BITS-1:0] kb;
        logic [KEY_BITS-1:0] flip;
        flip = {sk, {(KEY_BITS-1){1'b0}}};
        ka   = a[ENT_W-1 -: KEY_BITS] ^ flip;
        kb   = b[ENT_W-1 -: KEY_BITS] ^ flip;
        return lf ? (ka < kb) : (ka > kb);
    endfunction

    function automatic logic [KID_W-1:0] kid_left(input logic [IDX_W-1:0] i);
        return {1'b0, i, 1'b1};
    endfunction

    logic [2:0]                        state_reg, state_next;
    logic [CNT_W-1:0]                  cnt_reg, cnt_next;
    logic [IDX_W-1:0]                  pos_reg, pos_next;
    logic [ENT_W-1:0]                  mov_reg, mov_next;
    logic [ENT_W-1:0]                  res_ent_reg, res_ent_next;
    logic [bhpq_pkg::STATUS_W-1:0]     res_status_reg, res_status_next;
    logic                              largest_first_reg, signed_keys_reg;

    logic                              rsp_valid_reg, rsp_valid_next;
    logic [O_KEY_W-1:0]                rsp_key_reg, rsp_key_next;
    logic [O_PAY_W-1:0]                rsp_pay_reg, rsp_pay_next;
    logic [bhpq_pkg::STATUS_W-1:0]     rsp_status_reg, rsp_status_next;
    logic [O_HLD_W-1:0]                rsp_held_reg, rsp_held_next;

    logic                              st_we;
    logic [IDX_W-1:0]                  st_waddr;
    logic [ENT_W-1:0]                  st_wdata;
    logic [IDX_W-1:0]                  st_ra, st_rb;
    logic [ENT_W-1:0]                  rd_a, rd_b;

    logic [ENT_W-1:0]                  new_ent;
    logic [IDX_W-1:0]                  par_idx;
    logic [KID_W-1:0]                  cnt_w;
    logic [KID_W-1:0]                  lkid_w, rkid_w;
    logic                              r_ok;

    bhpq_store #(
        .DEPTH (CAPACITY),
        .WIDTH (ENT_W),
        .AW    (IDX_W)
    ) u_store (
        .clk     (clk),
        .we      (st_we),
        .waddr   (st_waddr),
        .wdata   (st_wdata),
        .raddr_a (st_ra),
        .raddr_b (st_rb),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    assign new_ent = {req.new_key[KEY_BITS-1:0], req.new_payload[PAYLOAD_BITS-1:0]};
    assign par_idx = (pos_reg - IDX_W'(1)) >> 1;
    assign cnt_w   = KID_W'(cnt_reg);
    assign lkid_w  = kid_left(pos_reg);
    assign rkid_w  = lkid_w + KID_W'(1);
    assign r_ok    = (rkid_w < cnt_w);

    always_comb
    begin
        logic             take;
        logic             take_r;
        logic [IDX_W-1:0] child;
        logic [ENT_W-1:0] cdata;

        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        mov_next        = mov_reg;
        res_ent_next    = res_ent_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_key_next    = rsp_key_reg;
        rsp_pay_next    = rsp_pay_reg;
        rsp_status_next = rsp_status_reg;
        rsp_held_next   = rsp_held_reg;
        st_we           = 1'b0;
        st_waddr        = pos_reg;
        st_wdata        = mov_reg;
        take            = 1'b0;
        take_r          = 1'b0;
        child           = lkid_w[IDX_W-1:0];
        cdata           = rd_a;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_ent_next    = '0;
                    res_status_next = bhpq_pkg::ST_DONE;
                    if (req.cmd == bhpq_pkg::CMD_INSERT)
                    begin
                        if (cnt_reg == CNT_W'(CAPACITY))
                        begin
                            res_status_next = bhpq_pkg::ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            mov_next = new_ent;
                            pos_next = cnt_reg[IDX_W-1:0];
                            cnt_next = cnt_reg + CNT_W'(1);
                            if (cnt_reg == '0)
                            begin
                                st_we      = 1'b1;
                                st_waddr   = '0;
                                st_wdata   = new_ent;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_UP_CMP;
                            end
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            res_status_next = bhpq_pkg::ST_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            cnt_next   = cnt_reg - CNT_W'(1);
                            pos_next   = '0;
                            state_next = S_DN_ROOT;
                        end
                    end
                end
            end

            S_UP_CMP:
            begin
                st_we = 1'b1;
                if (ranks_after(rd_a, mov_reg, largest_first_reg, signed_keys_reg))
                begin
                    // parent moves down into the hole
                    st_wdata   = rd_a;
                    pos_next   = par_idx;
                    state_next = (par_idx == '0) ? S_WR_MOV : S_UP_CMP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DN_ROOT:
            begin
                res_ent_next = rd_a;
                mov_next     = rd_b;
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (cnt_w > KID_W'(1))
                begin
                    state_next = S_DN_CMP;
                end
                else
                begin
                    state_next = S_WR_MOV;
                end
            end

            S_DN_CMP:
            begin
                if (r_ok)
                begin
                    if (ranks_after(mov_reg, rd_a, largest_first_reg, signed_keys_reg))
                    begin
                        take   = 1'b1;
                        take_r = ranks_after(rd_a, rd_b, largest_first_reg,
                                             signed_keys_reg);
                    end
                    else
                    begin
                        take   = ranks_after(mov_reg, rd_b, largest_first_reg,
                                             signed_keys_reg);
                        take_r = 1'b1;
                    end
                end
                else
                begin
                    take = ranks_after(mov_reg, rd_a, largest_first_reg, signed_keys_reg);
                end
                child = take_r ? rkid_w[IDX_W-1:0] : lkid_w[IDX_W-1:0];
                cdata = take_r ? rd_b : rd_a;
                st_we = 1'b1;
                if (take)
                begin
                    st_wdata   = cdata;
                    pos_next   = child;
                    state_next = (kid_left(child) < cnt_w) ? S_DN_CMP : S_WR_MOV;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_WR_MOV:
            begin
                st_we      = 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_key_next    = O_KEY_W'(res_ent_reg[ENT_W-1 -: KEY_BITS]);
                    rsp_pay_next    = O_PAY_W'(res_ent_reg[PAYLOAD_BITS-1:0]);
                    rsp_status_next = res_status_reg;
                    rsp_held_next   = O_HLD_W'(cnt_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // read addresses follow the next position so data lands for the next compare
    always_comb
    begin
        logic [KID_W-1:0] kl;
        logic [KID_W-1:0] kr;

        kl    = kid_left(pos_next);
        kr    = kl + KID_W'(1);
        st_ra = '0;
        st_rb = '0;
        case (state_next)
            S_UP_CMP:
            begin
                st_ra = (pos_next - IDX_W'(1)) >> 1;
            end
            S_DN_ROOT:
            begin
                st_rb = cnt_next[IDX_W-1:0];
            end
            S_DN_CMP:
            begin
                st_ra = kl[IDX_W-1:0];
                st_rb = (kr < KID_W'(cnt_next)) ? kr[IDX_W-1:0] : kl[IDX_W-1:0];
            end
            default:
            begin
                st_ra = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            cnt_reg           <= '0;
            rsp_valid_reg     <= 1'b0;
            largest_first_reg <= 1'b0;
            signed_keys_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    bhpq_pkg::CFG_LARGEST_FIRST: largest_first_reg <= cfg_data[0];
                    bhpq_pkg::CFG_SIGNED_KEYS:   signed_keys_reg   <= cfg_data[0];
                    default:                     largest_first_reg <= largest_first_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        mov_reg        <= mov_next;
        res_ent_reg    <= res_ent_next;
        res_status_reg <= res_status_next;
        rsp_key_reg    <= rsp_key_next;
        rsp_pay_reg    <= rsp_pay_next;
        rsp_status_reg <= rsp_status_next;
        rsp_held_reg   <= rsp_held_next;
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.top_key      = rsp_key_reg;
    assign rsp.top_payload  = rsp_pay_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.entries_held = rsp_held_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg != S_IDLE)
        else $error("sequencer idle right after accepting a request");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != bhpq_pkg::ST_DONE |->
            rsp.top_key == '0 && rsp.top_payload == '0)
        else $error("refused transaction carries data");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == bhpq_pkg::ST_EMPTY |-> rsp.entries_held == '0)
        else $error("empty refusal with nonzero entry count");

endmodule
